// ----- rtl/olad_pkg.sv -----
// Shared types and codes for the ordered list block.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package olad_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_LIST   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4,
    ST_LISTED   = 3'd5
  } status_t;

endpackage

// ----- rtl/olad_mem.sv -----
// Value store: one write port, one read port, registered read data.
// Depends on olad_pkg for the data width.
`timescale 1ns / 1ps

module olad_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [olad_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [olad_pkg::DATA_W-1:0] rdata
);
  import olad_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/olad_ctrl.sv -----
// Sequencer: append, streaming scan for delete (with compaction) and list.
// Depends on olad_pkg; drives the ports of olad_mem.
`timescale 1ns / 1ps

module olad_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  op,
  input  logic signed [olad_pkg::DATA_W-1:0] value,
  output logic                        busy,
  output logic                        strobe,
  output logic [2:0]                  status,
  output logic signed [olad_pkg::DATA_W-1:0] item,
  output logic                        last,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [olad_pkg::DATA_W-1:0] mem_wdata,
  output logic [AW-1:0]               mem_raddr,
  input  logic [olad_pkg::DATA_W-1:0] mem_rdata
);
  import olad_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t            state;
  op_t               op_r;
  logic [DATA_W-1:0] value_r;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rd_ptr;
  logic              pend_valid;
  logic [AW-1:0]     pend_idx;
  logic              found;

  logic              full;
  logic              is_last;
  logic              match;
  logic              app_write;
  logic              shift_write;

  assign busy     = rst || (state != S_IDLE);
  assign full     = (count == CW'(DEPTH));
  assign is_last  = (CW'(pend_idx) == (count - CW'(1)));
  assign match    = (mem_rdata == value_r);

  assign app_write   = (state == S_IDLE) && start && (op_t'(op) == OP_APPEND) && !full;
  assign shift_write = (state == S_SCAN) && pend_valid && (op_r == OP_DELETE) && found;

  assign mem_we    = app_write || shift_write;
  assign mem_waddr = app_write ? count[AW-1:0] : (pend_idx - AW'(1));
  assign mem_wdata = app_write ? value : mem_rdata;
  assign mem_raddr = rd_ptr[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rd_ptr     <= '0;
      pend_valid <= 1'b0;
      found      <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r       <= op_t'(op);
            value_r    <= value;
            rd_ptr     <= '0;
            pend_valid <= 1'b0;
            found      <= 1'b0;
            item       <= value;
            last       <= 1'b1;
            case (op_t'(op))
              OP_APPEND: begin
                strobe <= 1'b1;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_APPENDED;
                  count  <= count + CW'(1);
                end
              end
              OP_DELETE, OP_LIST: begin
                if (count == '0) begin
                  strobe <= 1'b1;
                  status <= ST_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                // unused code: no transaction result
              end
            endcase
          end
        end
        S_SCAN: begin
          // read issue side; the pointer has reached count by the tail entry
          if (rd_ptr < count) begin
            rd_ptr     <= rd_ptr + CW'(1);
            pend_valid <= 1'b1;
            pend_idx   <= rd_ptr[AW-1:0];
          end else begin
            pend_valid <= 1'b0;
          end
          // data return side
          if (pend_valid) begin
            if (op_r == OP_LIST) begin
              strobe <= 1'b1;
              status <= ST_LISTED;
              item   <= mem_rdata;
              last   <= is_last;
            end else if (match) begin
              found <= 1'b1;
            end
            if (is_last) begin
              state <= S_IDLE;
              if (op_r != OP_LIST) begin
                strobe <= 1'b1;
                item   <= value_r;
                last   <= 1'b1;
                if (found || match) begin
                  status <= ST_DELETED;
                  count  <= count - CW'(1);
                end else begin
                  status <= ST_NOTFOUND;
                end
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/ordered_list_append_delete.sv -----
// Ordered list of up to DEPTH signed 32-bit values in a one-port-read store.
// Append, and delete or list on an empty list: one result in the cycle after
// the request is taken; busy stays low. Delete and list with n entries stream
// the store once with busy high; list results come one per cycle, and the
// tail or delete result comes in the same cycle that busy falls.
// Synchronous active-high reset empties the list; store undefined until appended.
// Depends on olad_pkg, olad_ctrl and olad_mem.
`timescale 1ns / 1ps

module ordered_list_append_delete #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // request transaction: taken when start is high and busy is low
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         op,
  input  logic signed [olad_pkg::DATA_W-1:0] value,
  // result transaction: valid for the single cycle that strobe is high
  output logic                               strobe,
  output logic [2:0]                         status,
  output logic signed [olad_pkg::DATA_W-1:0] item,
  output logic                               last
);
  import olad_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Store port wiring. Delete compaction writes entry k-1 with the data of
  // entry k while reads run ahead, so a write never hits the read address.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  olad_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (op),
    .value     (value),
    .busy      (busy),
    .strobe    (strobe),
    .status    (status),
    .item      (item),
    .last      (last),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Entries 0..count-1 hold the list, head first.
  olad_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ----- rtl/olad_checker.sv -----
// Port-level checks for ordered_list_append_delete, bound to the top level.
// Depends on olad_pkg for the status and op codes.
`timescale 1ns / 1ps

module olad_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic [1:0]                         op,
  input logic signed [olad_pkg::DATA_W-1:0] value,
  input logic                               strobe,
  input logic [2:0]                         status,
  input logic signed [olad_pkg::DATA_W-1:0] item,
  input logic                               last
);
  import olad_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (status <= ST_LISTED))
    else $error("result status code out of range");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status != ST_LISTED)) |-> last)
    else $error("single-result transaction without last");

  // busy also covers reset, so its fall out of reset carries no result
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> (strobe && last))
    else $error("busy dropped without final result");

  a_append_echo: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (op == OP_APPEND)) |=>
      (strobe && last && ((status == ST_APPENDED) || (status == ST_FULL))
       && (item == $past(value))))
    else $error("append result missing or wrong");

endmodule

bind ordered_list_append_delete olad_checker u_olad_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .op     (op),
  .value  (value),
  .strobe (strobe),
  .status (status),
  .item   (item),
  .last   (last)
);
